>>> sv/slrd_pkg.sv
package slrd_pkg;

    localparam int unsigned COUNT_W = 17;
    localparam int unsigned MUL_W   = 17;
    localparam int unsigned PROD_W  = 2 * MUL_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'd65536;
    localparam logic [MUL_W-1:0]   SCALE_PCT = 17'd10000;
    localparam logic [MUL_W-1:0]   SCALE_100 = 17'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GREEN_MARGIN    = 3'd0,
        REG_BLUE_MARGIN     = 3'd1,
        REG_WHITE_RED_MIN   = 3'd2,
        REG_WHITE_GREEN_MIN = 3'd3,
        REG_WHITE_BLUE_MIN  = 3'd4,
        REG_BOX_CORNERS     = 3'd5,
        REG_STOP_PERCENT    = 3'd6
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_AREA,
        ST_P100,
        ST_LHS,
        ST_RHS,
        ST_CMP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [8:0] green_margin;
        logic [8:0] blue_margin;
        logic [7:0] white_red_min;
        logic [7:0] white_green_min;
        logic [7:0] white_blue_min;
        logic [7:0] box_left;
        logic [7:0] box_top;
        logic [7:0] box_right;
        logic [7:0] box_bottom;
    } slrd_cfg_t;

    // c*255/31 = 8c + floor(7c/31)
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [2:0] frac;
        begin
            frac = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
                 + 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
            expand5 = {c, 3'b000} + {5'b00000, frac};
        end
    endfunction

    // c*255/63 = 4c + floor(c/21)
    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [1:0] frac;
        begin
            frac = 2'(c >= 6'd21) + 2'(c >= 6'd42) + 2'(c >= 6'd63);
            expand6 = {c, 2'b00} + {6'b000000, frac};
        end
    endfunction

endpackage

>>> sv/slrd_classify.sv
module slrd_classify
(
    input  slrd_pkg::slrd_cfg_t cfg,
    input  logic [15:0]         pixel_value,
    input  logic [7:0]          column,
    input  logic [7:0]          row,
    output logic                mask
);

    logic [7:0] r8;
    logic [7:0] g8;
    logic [7:0] b8;
    logic [9:0] g_need;
    logic [9:0] b_need;
    logic       red_enough;
    logic       white;
    logic       in_box;

    assign r8 = slrd_pkg::expand5(pixel_value[15:11]);
    assign g8 = slrd_pkg::expand6(pixel_value[10:5]);
    assign b8 = slrd_pkg::expand5(pixel_value[4:0]);

    assign g_need = {2'b00, g8} + {1'b0, cfg.green_margin};
    assign b_need = {2'b00, b8} + {1'b0, cfg.blue_margin};

    assign red_enough = ({2'b00, r8} >= g_need) && ({2'b00, r8} >= b_need);
    assign white      = (r8 >= cfg.white_red_min) && (g8 >= cfg.white_green_min)
                     && (b8 >= cfg.white_blue_min);
    assign in_box     = (column >= cfg.box_left) && (column <= cfg.box_right)
                     && (row >= cfg.box_top) && (row <= cfg.box_bottom);

    assign mask = in_box && red_enough && !white;

endmodule

>>> sv/slrd_mul.sv
module slrd_mul
(
    input  logic                              clk,
    input  logic [slrd_pkg::MUL_W-1:0]        a,
    input  logic [slrd_pkg::MUL_W-1:0]        b,
    output logic [slrd_pkg::PROD_W-1:0]       prod
);

    logic [slrd_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {{slrd_pkg::MUL_W{1'b0}}, a} * {{slrd_pkg::MUL_W{1'b0}}, b};
    end

    assign prod = prod_reg;

endmodule

>>> sv/stop_line_region_detector_unit.sv
// An ordinary pixel goes idle, classify, output; a frame-end pixel with a valid
// box also runs area, p100, lhs, rhs, compare (four passes through the shared
// multiplier). Input ready only in idle, so a new item waits for the last one;
// a finished item may still wait in the output register.
// Reset (rst_n low, asynchronous): count cleared, registers to defaults,
// no item held.
module stop_line_region_detector_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [slrd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [slrd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [15:0]                       pixel_value,
    input  logic [7:0]                        column,
    input  logic [7:0]                        row,
    input  logic                              frame_end,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              mask_bit,
    output logic                              frame_done,
    output logic                              stop_found,
    output logic [slrd_pkg::COUNT_W-1:0]      marked_total
);

    slrd_pkg::slrd_cfg_t cfg_reg;
    logic [6:0]          stop_percent_reg;

    slrd_pkg::state_t state_reg;
    slrd_pkg::state_t state_next;

    logic [15:0] pix_reg;
    logic [7:0]  col_reg;
    logic [7:0]  row_reg;
    logic        last_reg;
    logic        mask_reg;
    logic        mask_next;
    logic        stop_reg;
    logic        stop_next;
    logic [16:0] count_reg;
    logic [16:0] count_next;
    logic [16:0] total_reg;
    logic [16:0] total_next;
    logic [16:0] area_reg;
    logic [16:0] area_next;
    logic [16:0] p100_reg;
    logic [16:0] p100_next;
    logic [33:0] lhs_reg;
    logic [33:0] lhs_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_mask_reg;
    logic        out_last_reg;
    logic        out_stop_reg;
    logic [16:0] out_total_reg;
    logic        out_load;

    logic        pix_mask;
    logic        box_ok;
    logic [8:0]  box_w;
    logic [8:0]  box_h;
    logic [16:0] mul_a;
    logic [16:0] mul_b;
    logic [33:0] mul_p;
    logic [16:0] count_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.green_margin    <= 9'd0;
            cfg_reg.blue_margin     <= 9'd0;
            cfg_reg.white_red_min   <= 8'd255;
            cfg_reg.white_green_min <= 8'd255;
            cfg_reg.white_blue_min  <= 8'd255;
            cfg_reg.box_left        <= 8'd0;
            cfg_reg.box_top         <= 8'd0;
            cfg_reg.box_right       <= 8'd0;
            cfg_reg.box_bottom      <= 8'd0;
            stop_percent_reg        <= 7'd100;
        end
        else if (cfg_write)
        begin
            case (slrd_pkg::reg_index_t'(cfg_index))
                slrd_pkg::REG_GREEN_MARGIN:    cfg_reg.green_margin    <= cfg_data[8:0];
                slrd_pkg::REG_BLUE_MARGIN:     cfg_reg.blue_margin     <= cfg_data[8:0];
                slrd_pkg::REG_WHITE_RED_MIN:   cfg_reg.white_red_min   <= cfg_data[7:0];
                slrd_pkg::REG_WHITE_GREEN_MIN: cfg_reg.white_green_min <= cfg_data[7:0];
                slrd_pkg::REG_WHITE_BLUE_MIN:  cfg_reg.white_blue_min  <= cfg_data[7:0];
                slrd_pkg::REG_BOX_CORNERS:
                begin
                    cfg_reg.box_left   <= cfg_data[7:0];
                    cfg_reg.box_top    <= cfg_data[15:8];
                    cfg_reg.box_right  <= cfg_data[23:16];
                    cfg_reg.box_bottom <= cfg_data[31:24];
                end
                slrd_pkg::REG_STOP_PERCENT:    stop_percent_reg <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    slrd_classify u_classify
    (
        .cfg         (cfg_reg),
        .pixel_value (pix_reg),
        .column      (col_reg),
        .row         (row_reg),
        .mask        (pix_mask)
    );

    slrd_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p)
    );

    assign box_ok = (cfg_reg.box_right >= cfg_reg.box_left)
                 && (cfg_reg.box_bottom >= cfg_reg.box_top);
    assign box_w  = {1'b0, cfg_reg.box_right} - {1'b0, cfg_reg.box_left} + 9'd1;
    assign box_h  = {1'b0, cfg_reg.box_bottom} - {1'b0, cfg_reg.box_top} + 9'd1;

    assign count_inc = (pix_mask && (count_reg < slrd_pkg::COUNT_MAX))
                     ? count_reg + 17'd1 : count_reg;

    assign out_load = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        mask_next      = mask_reg;
        stop_next      = stop_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        area_next      = area_reg;
        p100_next      = p100_reg;
        lhs_next       = lhs_reg;
        out_valid_next = out_valid_reg && !out_ready;
        mul_a          = 17'd0;
        mul_b          = 17'd0;
        in_ready       = 1'b0;

        case (state_reg)
            slrd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = slrd_pkg::ST_CLASS;
                end
            end
            slrd_pkg::ST_CLASS:
            begin
                mask_next  = pix_mask;
                total_next = count_inc;
                stop_next  = 1'b0;
                count_next = last_reg ? 17'd0 : count_inc;
                state_next = (last_reg && box_ok) ? slrd_pkg::ST_AREA : slrd_pkg::ST_OUT;
            end
            slrd_pkg::ST_AREA:
            begin
                mul_a      = {8'd0, box_w};
                mul_b      = {8'd0, box_h};
                state_next = slrd_pkg::ST_P100;
            end
            slrd_pkg::ST_P100:
            begin
                area_next  = mul_p[16:0];
                mul_a      = {10'd0, stop_percent_reg};
                mul_b      = slrd_pkg::SCALE_100;
                state_next = slrd_pkg::ST_LHS;
            end
            slrd_pkg::ST_LHS:
            begin
                p100_next  = mul_p[16:0];
                mul_a      = total_reg;
                mul_b      = slrd_pkg::SCALE_PCT;
                state_next = slrd_pkg::ST_RHS;
            end
            slrd_pkg::ST_RHS:
            begin
                lhs_next   = mul_p;
                mul_a      = area_reg;
                mul_b      = p100_reg;
                state_next = slrd_pkg::ST_CMP;
            end
            slrd_pkg::ST_CMP:
            begin
                stop_next  = lhs_reg >= mul_p;
                state_next = slrd_pkg::ST_OUT;
            end
            slrd_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = slrd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = slrd_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slrd_pkg::ST_IDLE;
            count_reg     <= 17'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pix_reg  <= pixel_value;
            col_reg  <= column;
            row_reg  <= row;
            last_reg <= frame_end;
        end
        mask_reg  <= mask_next;
        stop_reg  <= stop_next;
        total_reg <= total_next;
        area_reg  <= area_next;
        p100_reg  <= p100_next;
        lhs_reg   <= lhs_next;
        if ((state_reg == slrd_pkg::ST_OUT) && out_load)
        begin
            out_mask_reg  <= mask_reg;
            out_last_reg  <= last_reg;
            out_stop_reg  <= stop_reg;
            out_total_reg <= total_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign mask_bit     = out_mask_reg;
    assign frame_done   = out_last_reg;
    assign stop_found   = out_stop_reg;
    assign marked_total = out_total_reg;

endmodule

>>> tb/tb_stop_line_region_detector_unit.sv
module tb_stop_line_region_detector_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] NO_SUCH_REG = 3'd7;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  column;
        logic [7:0]  row;
        logic        last;
    } pixel_item_t;

    typedef struct packed {
        logic        marked;
        logic        frame_last;
        logic        stop;
        logic [16:0] total;
    } stop_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] pixel_value = '0;
    logic [7:0]  column = '0;
    logic [7:0]  row = '0;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        mask_bit;
    logic        frame_done;
    logic        stop_found;
    logic [16:0] marked_total;

    // predictor copy of the register file and the running count
    logic [8:0]  min_red_over_green = 9'd0;
    logic [8:0]  min_red_over_blue = 9'd0;
    logic [7:0]  white_red = 8'd255;
    logic [7:0]  white_green = 8'd255;
    logic [7:0]  white_blue = 8'd255;
    logic [31:0] box_word = 32'd0;
    logic [6:0]  percent_needed = 7'd100;
    int unsigned stop_count = 0;

    pixel_item_t  pixel_q[$];
    stop_result_t result_q[$];
    pixel_item_t  next_pixel;
    logic         item_taken = 1'b0;

    int send_idle_pct = 35;
    int recv_idle_pct = 81;
    int errors = 0;
    int cycle_count = 0;
    int results_seen = 0;
    int frames_seen = 0;
    int stops_seen = 0;
    int settings_used = 0;

    stop_line_region_detector_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_value  (pixel_value),
        .column       (column),
        .row          (row),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mask_bit     (mask_bit),
        .frame_done   (frame_done),
        .stop_found   (stop_found),
        .marked_total (marked_total)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic stop_result_t predict_pixel(input pixel_item_t p);
        int unsigned red, green, blue;
        int unsigned left, top, right, bottom, area;
        longint unsigned ratio;
        logic in_box, reddish, white;
        stop_result_t res;
        red    = int'(p.value[15:11]) * 255 / 31;
        green  = int'(p.value[10:5]) * 255 / 63;
        blue   = int'(p.value[4:0]) * 255 / 31;
        left   = 32'(box_word[7:0]);
        top    = 32'(box_word[15:8]);
        right  = 32'(box_word[23:16]);
        bottom = 32'(box_word[31:24]);
        in_box = p.column >= left && p.column <= right && p.row >= top && p.row <= bottom;
        reddish = red >= green + min_red_over_green && red >= blue + min_red_over_blue;
        white = red >= white_red && green >= white_green && blue >= white_blue;
        res.marked = in_box && reddish && !white;
        res.frame_last = p.last;
        res.stop = 1'b0;
        if (res.marked && stop_count < slrd_pkg::COUNT_MAX)
            stop_count++;
        res.total = 17'(stop_count);
        if (p.last)
        begin
            if (right >= left && bottom >= top)
            begin
                area = (right - left + 1) * (bottom - top + 1);
                ratio = (longint'(stop_count) * 10000) / area;
                res.stop = ratio >= percent_needed * 100;
            end
            stop_count = 0;
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // check the outgoing result first, then record the incoming pixel
    always @(posedge clk)
    begin : watch_ports
        stop_result_t want;
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (frame_done)
                frames_seen++;
            if (stop_found)
                stops_seen++;
            if (result_q.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, actual mask %0b done %0b stop %0b total %0d",
                         $time, mask_bit, frame_done, stop_found, marked_total);
            end
            else
            begin
                want = result_q.pop_front();
                check_field("mask_bit", want.marked, mask_bit);
                check_field("frame_done", want.frame_last, frame_done);
                check_field("stop_found", want.stop, stop_found);
                check_field("marked_total", want.total, marked_total);
            end
        end
        if (in_valid && in_ready)
            result_q.push_back(predict_pixel({pixel_value, column, row, frame_end}));
        item_taken <= in_valid && in_ready;
    end

    always @(negedge clk)
    begin
        if (!in_valid || item_taken)
        begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_pixel = pixel_q.pop_front();
                in_valid    <= 1'b1;
                pixel_value <= next_pixel.value;
                column      <= next_pixel.column;
                row         <= next_pixel.row;
                frame_end   <= next_pixel.last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        out_ready <= $urandom_range(99) >= recv_idle_pct;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            slrd_pkg::REG_GREEN_MARGIN:    min_red_over_green = data[8:0];
            slrd_pkg::REG_BLUE_MARGIN:     min_red_over_blue = data[8:0];
            slrd_pkg::REG_WHITE_RED_MIN:   white_red = data[7:0];
            slrd_pkg::REG_WHITE_GREEN_MIN: white_green = data[7:0];
            slrd_pkg::REG_WHITE_BLUE_MIN:  white_blue = data[7:0];
            slrd_pkg::REG_BOX_CORNERS:     box_word = data;
            slrd_pkg::REG_STOP_PERCENT:    percent_needed = data[6:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pixel_q.size() != 0 || in_valid || result_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_pixel(input logic [15:0] value, input logic [7:0] x,
                               input logic [7:0] y, input logic last);
        pixel_q.push_back('{value, x, y, last});
    endtask

    function automatic logic [31:0] pick_margin();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return 32'd511;
        if (pick < 20)
            return 32'd0;
        return (32'($urandom) << 9) | 32'($urandom_range(60));
    endfunction

    function automatic logic [31:0] pick_white();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return 32'd0;
        if (pick < 25)
            return 32'd255;
        return (32'($urandom) << 8) | 32'($urandom_range(255, 128));
    endfunction

    task automatic pick_settings();
        logic [7:0] l, t, r, b;
        int pick;
        logic [31:0] pct;
        write_reg(slrd_pkg::REG_GREEN_MARGIN, pick_margin());
        write_reg(slrd_pkg::REG_BLUE_MARGIN, pick_margin());
        write_reg(slrd_pkg::REG_WHITE_RED_MIN, pick_white());
        write_reg(slrd_pkg::REG_WHITE_GREEN_MIN, pick_white());
        write_reg(slrd_pkg::REG_WHITE_BLUE_MIN, pick_white());
        pick = $urandom_range(99);
        l = 8'($urandom);
        t = 8'($urandom);
        r = (l > 8'd250) ? 8'd255 : 8'(l + $urandom_range(5));
        b = (t > 8'd250) ? 8'd255 : 8'(t + $urandom_range(5));
        if (pick >= 60 && pick < 70)
        begin
            l = 8'($urandom_range(255, 1));
            r = 8'($urandom_range(l - 1, 0));
        end
        else if (pick >= 70 && pick < 75)
        begin
            t = 8'($urandom_range(255, 1));
            b = 8'($urandom_range(t - 1, 0));
        end
        else if (pick >= 75 && pick < 90)
        begin
            l = 8'd0;
            t = 8'd0;
            r = 8'd255;
            b = 8'd255;
        end
        else if (pick >= 90)
        begin
            r = 8'($urandom);
            b = 8'($urandom);
        end
        write_reg(slrd_pkg::REG_BOX_CORNERS, {b, r, t, l});
        pick = $urandom_range(99);
        if (pick < 10)
            pct = 32'd0;
        else if (pick < 20)
            pct = 32'd100;
        else if (pick < 28)
            pct = 32'($urandom_range(127, 101));
        else if (pick < 45)
            pct = 32'($urandom_range(100));
        else
            pct = 32'($urandom_range(60));
        write_reg(slrd_pkg::REG_STOP_PERCENT, (32'($urandom) << 7) | pct);
        settings_used++;
    endtask

    // mostly frames of reddish pixels inside the box, some near its edges, some noise
    task automatic queue_frames(input int n_items);
        int unsigned left, top, right, bottom;
        int len, k, mode, shade;
        pixel_item_t p;
        left   = 32'(box_word[7:0]);
        top    = 32'(box_word[15:8]);
        right  = 32'(box_word[23:16]);
        bottom = 32'(box_word[31:24]);
        while (n_items > 0)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            if (len > n_items)
                len = n_items;
            for (k = 0; k < len; k++)
            begin
                mode = $urandom_range(99);
                p.value  = 16'($urandom);
                p.column = 8'($urandom);
                p.row    = 8'($urandom);
                p.last   = (k == len - 1);
                if (mode < 75 && right >= left && bottom >= top)
                begin
                    p.column = 8'($urandom_range(right, left));
                    p.row    = 8'($urandom_range(bottom, top));
                end
                else if (mode < 88)
                begin
                    p.column = $urandom_range(1) ? 8'(left - 1) : 8'(right + 1);
                    p.row    = $urandom_range(1) ? 8'(top) : 8'(bottom + 1);
                end
                else if (mode >= 96)
                begin
                    p.last = 1'($urandom_range(1));
                end
                shade = $urandom_range(99);
                if (shade < 55)
                    p.value = {5'($urandom_range(31, 14)), 6'($urandom_range(20)),
                               5'($urandom_range(8))};
                else if (shade < 63)
                    p.value = 16'hFFFF;
                else if (shade < 68)
                    p.value = 16'h0000;
                pixel_q.push_back(p);
            end
            n_items -= len;
        end
    endtask

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // register defaults: one-pixel box at the origin, full percentage
        queue_pixel(16'hF800, 8'd0, 8'd0, 1'b1);
        queue_pixel(16'hFFFF, 8'd0, 8'd0, 1'b1);
        queue_pixel(16'h0000, 8'd0, 8'd0, 1'b0);
        queue_pixel(16'hF800, 8'd1, 8'd0, 1'b0);
        queue_pixel(16'hF800, 8'd0, 8'd1, 1'b0);
        queue_pixel(16'h07E0, 8'd0, 8'd0, 1'b0);
        queue_pixel(16'h001F, 8'd255, 8'd255, 1'b1);
        wait_idle();

        // empty box with zero percent still gives no stop
        write_reg(slrd_pkg::REG_BOX_CORNERS, {8'd3, 8'd5, 8'd3, 8'd10});
        write_reg(slrd_pkg::REG_STOP_PERCENT, 32'd0);
        queue_pixel(16'hF800, 8'd10, 8'd3, 1'b0);
        queue_pixel(16'hF800, 8'd5, 8'd3, 1'b1);
        wait_idle();

        // whole frame box, margins out of reach
        write_reg(slrd_pkg::REG_BOX_CORNERS, {8'd255, 8'd255, 8'd0, 8'd0});
        write_reg(slrd_pkg::REG_GREEN_MARGIN, 32'hFFFF_FFFF);
        write_reg(slrd_pkg::REG_BLUE_MARGIN, 32'hFFFF_FFFF);
        queue_pixel(16'hF800, 8'd255, 8'd255, 1'b0);
        queue_pixel(16'hF81F, 8'd128, 8'd7, 1'b1);
        wait_idle();

        // everything counts as white; percent above 100; write to a missing register
        write_reg(slrd_pkg::REG_GREEN_MARGIN, 32'd0);
        write_reg(slrd_pkg::REG_BLUE_MARGIN, 32'd0);
        write_reg(slrd_pkg::REG_WHITE_RED_MIN, 32'hFFFF_FF00);
        write_reg(slrd_pkg::REG_WHITE_GREEN_MIN, 32'hFFFF_FF00);
        write_reg(slrd_pkg::REG_WHITE_BLUE_MIN, 32'hFFFF_FF00);
        write_reg(slrd_pkg::REG_STOP_PERCENT, 32'hFFFF_FFFF);
        write_reg(NO_SUCH_REG, 32'd0);
        queue_pixel(16'hF800, 8'd3, 8'd200, 1'b0);
        queue_pixel(16'h0000, 8'd4, 8'd4, 1'b1);
        wait_idle();

        write_reg(slrd_pkg::REG_WHITE_RED_MIN, 32'd255);
        write_reg(slrd_pkg::REG_WHITE_GREEN_MIN, 32'd255);
        write_reg(slrd_pkg::REG_WHITE_BLUE_MIN, 32'd255);
        write_reg(slrd_pkg::REG_BOX_CORNERS, 32'd0);
        queue_pixel(16'hF800, 8'd0, 8'd0, 1'b1);
        wait_idle();

        for (phase = 0; phase < 24; phase++)
        begin
            if (phase == 8)
            begin
                send_idle_pct = 81;
                recv_idle_pct = 35;
            end
            if (phase == 16)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            pick_settings();
            queue_frames(75);
            wait_idle();
        end

        $display("Checked %0d pixel results in %0d frames over %0d random register settings,",
                 results_seen, frames_seen, settings_used);
        $display("stop reported on %0d frames, plus empty boxes, white levels and a missing register.",
                 stops_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
